@@ rtl/rgbtex_pkg.sv @@
// Shared types and constants for the RGB24 to texture pixel converter.
// Used by rgbtex_cfg, rgbtex_core and the top level; depends on nothing.
package rgbtex_pkg;

    // Dimension registers and counters
    localparam int unsigned DIM_W   = 13;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned TEXEL_W = 32;

    localparam logic [DIM_W-1:0] MAX_WIDTH      = 13'd4096;
    localparam logic [DIM_W-1:0] MAX_HEIGHT     = 13'd4096;
    localparam logic [DIM_W-1:0] WIDTH_AT_RST   = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_AT_RST  = 13'd480;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_TARGET_FORMAT = 2'd2
    } t_cfg_reg;

    // Output pixel formats
    typedef enum logic {
        FMT_XRGB8888 = 1'b0,
        FMT_ARGB1555 = 1'b1
    } t_format;

    // Byte position within a source pixel
    typedef enum logic [1:0] {
        PH_BLUE  = 2'd0,
        PH_GREEN = 2'd1,
        PH_RED   = 2'd2
    } t_phase;

    // Active configuration, dimensions already clamped to 1..max
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        t_format          format;
    } t_cfg;

    // One step result from the unpacker
    typedef struct packed {
        logic               valid;
        logic [TEXEL_W-1:0] texel;
        logic               row_end;
        logic               frame_end;
    } t_pixel;

endpackage

@@ rtl/rgbtex_cfg.sv @@
// Configuration registers: frame width, frame height and target format.
// Depends on rgbtex_pkg; dimensions are clamped to 1..max when written.
module rgbtex_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [rgbtex_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [rgbtex_pkg::DIM_W-1:0]   i_cfg_wdata,
    output rgbtex_pkg::t_cfg               o_cfg
);

    rgbtex_pkg::t_cfg r_cfg;
    rgbtex_pkg::t_cfg n_cfg;

    // Zero reads as one, anything above the maximum saturates
    function automatic logic [rgbtex_pkg::DIM_W-1:0] clamp_dim(
        input logic [rgbtex_pkg::DIM_W-1:0] v,
        input logic [rgbtex_pkg::DIM_W-1:0] maxv
    );
        logic [rgbtex_pkg::DIM_W-1:0] res;
        if (v == '0) begin
            res = {{(rgbtex_pkg::DIM_W-1){1'b0}}, 1'b1};
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Decode the write; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (rgbtex_pkg::t_cfg_reg'(i_cfg_index))
                rgbtex_pkg::CFG_FRAME_WIDTH: begin
                    n_cfg.width = clamp_dim(i_cfg_wdata, rgbtex_pkg::MAX_WIDTH);
                end
                rgbtex_pkg::CFG_FRAME_HEIGHT: begin
                    n_cfg.height = clamp_dim(i_cfg_wdata, rgbtex_pkg::MAX_HEIGHT);
                end
                rgbtex_pkg::CFG_TARGET_FORMAT: begin
                    n_cfg.format = rgbtex_pkg::t_format'(i_cfg_wdata[0]);
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= rgbtex_pkg::WIDTH_AT_RST;
            r_cfg.height <= rgbtex_pkg::HEIGHT_AT_RST;
            r_cfg.format <= rgbtex_pkg::FMT_XRGB8888;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/rgbtex_core.sv @@
// Byte unpacker: assembles blue/green/red into a texel, drops row padding
// and tracks column and row position. Depends on rgbtex_pkg.
module rgbtex_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  rgbtex_pkg::t_cfg     i_cfg,
    output rgbtex_pkg::t_pixel   o_pixel
);

    localparam int unsigned DW = rgbtex_pkg::DIM_W;

    rgbtex_pkg::t_phase r_phase, n_phase;
    logic [7:0]         r_blue, n_blue;
    logic [7:0]         r_green, n_green;
    logic [DW-1:0]      r_col, n_col;
    logic [DW-1:0]      r_row, n_row;
    logic [1:0]         r_pad, n_pad;

    logic [DW:0]        col_inc;
    logic [DW:0]        row_inc;
    logic               last_col;
    logic               last_row;
    logic [31:0]        texel;

    assign col_inc  = {1'b0, r_col} + {{DW{1'b0}}, 1'b1};
    assign row_inc  = {1'b0, r_row} + {{DW{1'b0}}, 1'b1};
    assign last_col = (col_inc >= {1'b0, i_cfg.width});
    assign last_row = (row_inc >= {1'b0, i_cfg.height});

    // Pack the current byte as red with the held green and blue
    always_comb begin
        if (i_cfg.format == rgbtex_pkg::FMT_ARGB1555) begin
            texel = {16'h0000, 1'b1, i_byte[7:3], r_green[7:3], r_blue[7:3]};
        end else begin
            texel = {8'hFF, i_byte, r_green, r_blue};
        end
    end

    // Advance the byte position, padding and counters
    always_comb begin
        n_phase = r_phase;
        n_blue  = r_blue;
        n_green = r_green;
        n_col   = r_col;
        n_row   = r_row;
        n_pad   = r_pad;
        o_pixel.valid     = 1'b0;
        o_pixel.texel     = texel;
        o_pixel.row_end   = last_col;
        o_pixel.frame_end = last_col && last_row;
        if (r_pad != 2'd0) begin
            n_pad = r_pad - 2'd1;
        end else begin
            case (r_phase)
                rgbtex_pkg::PH_GREEN: begin
                    n_green = i_byte;
                    n_phase = rgbtex_pkg::PH_RED;
                end
                rgbtex_pkg::PH_RED: begin
                    o_pixel.valid = 1'b1;
                    n_phase = rgbtex_pkg::PH_BLUE;
                    if (last_col) begin
                        n_col = '0;
                        n_pad = i_cfg.width[1:0];
                        n_row = last_row ? '0 : row_inc[DW-1:0];
                    end else begin
                        n_col = col_inc[DW-1:0];
                    end
                end
                default: begin
                    // blue, and the unused code
                    n_blue  = i_byte;
                    n_phase = rgbtex_pkg::PH_GREEN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rgbtex_pkg::PH_BLUE;
            r_blue  <= '0;
            r_green <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_pad   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_blue  <= n_blue;
            r_green <= n_green;
            r_col   <= n_col;
            r_row   <= n_row;
            r_pad   <= n_pad;
        end
    end

endmodule

@@ rtl/rgb24_to_texture_pixel_converter.sv @@
// Top level of the RGB24 to texture pixel converter: input byte register,
// unpacker, result register. Depends on rgbtex_pkg, rgbtex_cfg, rgbtex_core.
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+--------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata[7:0] source_byte
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata texel, tlast row_end,
//           |           |                               | tuser[0] frame_end
//  cfg      | in        | i_cfg_wr_en                   | i_cfg_index, i_cfg_wdata
//
// One byte is taken per cycle while the input register can accept it; every third non-pad
// byte yields one texel, presented through the input register, then the result register.
// The unpacker between the two registers forms each result combinationally from its state.
// Reset is synchronous; it clears both registers, the unpacker state and
// loads the default configuration. A stalled output holds the result and
// still lets one more byte into the input register.
module rgb24_to_texture_pixel_converter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] source_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [rgbtex_pkg::TEXEL_W-1:0]      m_axis_tdata,  // [31:0] texel
    output logic                                m_axis_tlast,  // row_end
    output logic [0:0]                          m_axis_tuser,  // [0] frame_end
    input  logic                                i_cfg_wr_en,
    input  logic [rgbtex_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [rgbtex_pkg::DIM_W-1:0]        i_cfg_wdata
);

    rgbtex_pkg::t_cfg   cfg;
    rgbtex_pkg::t_pixel pixel;

    logic                             r_in_valid;
    logic [7:0]                       r_in_byte;
    logic                             r_out_valid;
    logic [rgbtex_pkg::TEXEL_W-1:0]   r_out_texel;
    logic                             r_out_row_end;
    logic                             r_out_frame_end;
    logic                             advance;

    rgbtex_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    rgbtex_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .i_cfg   (cfg),
        .o_pixel (pixel)
    );

    // Move the held byte on when the result register is free or draining
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Input byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Result register: load on advance, drop after the output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= pixel.valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && pixel.valid) begin
            r_out_texel     <= pixel.texel;
            r_out_row_end   <= pixel.row_end;
            r_out_frame_end <= pixel.frame_end;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_texel;
    assign m_axis_tlast    = r_out_row_end;
    assign m_axis_tuser[0] = r_out_frame_end;

`ifndef SYNTHESIS
    a_frame_end_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("frame end without row end");

    a_ready_only_blocked_by_full_input: assert property (@(posedge i_clk)
        !s_axis_tready |-> r_in_valid)
        else $error("input stalled with empty input register");

    a_texel_format: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out_texel[31:24] == 8'hFF)
                       || (r_out_texel[31:16] == 16'h0000 && r_out_texel[15]))
        else $error("texel matches neither output format");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !r_out_valid && !r_in_valid)
        else $error("pipeline not empty after reset");
`endif

endmodule
